// File: rtl/unique_key_table_compacting_macros.svh
// Assertion macros shared by the checker of the unique key table.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef UNIQUE_KEY_TABLE_COMPACTING_MACROS_SVH
`define UNIQUE_KEY_TABLE_COMPACTING_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UKT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("unique key table assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define UKT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("unique key table assertion failed");

`endif

// File: rtl/ukt_pkg.sv
// Package of the unique key table: sizes, request codes, FSM states and the
// control bundle broadcast to the cells. Depends on nothing.
package ukt_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 8;
    localparam int OUT_CNT_W = 7;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IN_W     = 48;
    localparam int OUT_W    = 16;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_COMMIT = 1'b1
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] rem_idx;
        logic             do_insert;
        logic             do_remove;
    } ukt_ctrl_t;

endpackage

// File: rtl/ukt_cell.sv
// One slot of the unique key table: holds a key and a value, compares the
// broadcast key and takes its right neighbor's entry on a remove.
// Depends on ukt_pkg.
module ukt_cell (
    input  logic                      clk,
    input  logic [ukt_pkg::IDX_W-1:0] my_idx,
    input  ukt_pkg::ukt_ctrl_t        ctrl,
    input  logic [ukt_pkg::KEY_W-1:0] nbr_key,
    input  logic [ukt_pkg::VAL_W-1:0] nbr_value,
    output logic [ukt_pkg::KEY_W-1:0] key,
    output logic [ukt_pkg::VAL_W-1:0] value,
    output logic                      match
);
    import ukt_pkg::*;

    logic [KEY_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0] idx_ext;
    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] rem_ext;

    assign idx_ext = CNT_W'(my_idx);
    assign idx_inc = idx_ext + CNT_W'(1);
    assign rem_ext = CNT_W'(ctrl.rem_idx);

    // Entries are packed, so a slot is valid exactly when it lies below the count.
    assign match = (idx_ext < ctrl.count) && (key_reg == ctrl.key);
    assign key   = key_reg;
    assign value = value_reg;

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        if (ctrl.do_insert && (idx_ext == ctrl.count))
        begin
            key_next   = ctrl.key;
            value_next = ctrl.value;
        end
        else if (ctrl.do_remove && (idx_ext >= rem_ext))
        begin
            if (idx_inc < ctrl.count)
            begin
                key_next   = nbr_key;
                value_next = nbr_value;
            end
            else if (idx_inc == ctrl.count)
            begin
                key_next   = '0;
                value_next = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

endmodule

// File: rtl/unique_key_table_compacting.sv
// A request is handled in states ST_IDLE and ST_COMMIT: in ST_IDLE the key is compared against every
// cell at once and the hit slot is encoded and registered; in ST_COMMIT the insert or the
// one-place shift of the cell chain is committed and the result register is
// loaded. The commit waits while an earlier result is still held on the
// output, and no new request is accepted until the current one is committed.
// The table holds CAPACITY entries packed in insertion order.
// Depends on ukt_pkg and ukt_cell.
module unique_key_table_compacting (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // tdata from bit 0: op[1:0], key[33:2], value[41:34], zero fill [47:42]
    input  logic [ukt_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // tdata from bit 0: ok[0], found_value[8:1], entry_count[15:9]
    output logic [ukt_pkg::OUT_W-1:0] m_axis_tdata
);
    import ukt_pkg::*;

    state_t state_reg, state_next;
    logic   commit;

    op_t              op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [VAL_W-1:0] fv_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    logic                 out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]     out_data_reg;

    logic [KEY_W-1:0] in_key;
    logic             hit_any;
    logic [IDX_W-1:0] hit_idx;
    logic [VAL_W-1:0] hit_value;
    logic             insert_ok, find_ok, remove_ok, ok;

    ukt_ctrl_t        ctrl;
    logic [KEY_W-1:0] cell_key   [CAPACITY];
    logic [VAL_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0] cell_match;

    assign in_key = s_axis_tdata[33:2];

    always_comb
    begin
        state_next    = state_reg;
        commit        = 1'b0;
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Keys are unique among valid slots, so at most one cell matches and the
    // index and value can be gathered with a plain OR.
    always_comb
    begin
        hit_idx   = '0;
        hit_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cell_match[i])
            begin
                hit_idx   = hit_idx | IDX_W'(i);
                hit_value = hit_value | cell_value[i];
            end
        end
    end

    assign hit_any = |cell_match;

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            op_reg      <= op_t'(s_axis_tdata[1:0]);
            key_reg     <= in_key;
            value_reg   <= s_axis_tdata[41:34];
            hit_reg     <= hit_any;
            hit_idx_reg <= hit_idx;
            fv_reg      <= hit_value;
        end
    end

    assign insert_ok = (op_reg == OP_INSERT) && !hit_reg &&
                       (count_reg < CNT_W'(CAPACITY));
    assign find_ok   = (op_reg == OP_FIND) && hit_reg;
    assign remove_ok = (op_reg == OP_REMOVE) && hit_reg;
    assign ok        = insert_ok || find_ok || remove_ok;

    always_comb
    begin
        count_next = count_reg;
        if (insert_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (remove_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        ctrl.key       = (state_reg == ST_IDLE) ? in_key : key_reg;
        ctrl.value     = value_reg;
        ctrl.count     = count_reg;
        ctrl.rem_idx   = hit_idx_reg;
        ctrl.do_insert = commit && insert_ok;
        ctrl.do_remove = commit && remove_ok;
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [KEY_W-1:0] nbr_key;
        logic [VAL_W-1:0] nbr_value;
        if (i + 1 < CAPACITY)
        begin : g_mid
            assign nbr_key   = cell_key[i + 1];
            assign nbr_value = cell_value[i + 1];
        end
        else
        begin : g_end
            assign nbr_key   = '0;
            assign nbr_value = '0;
        end
        ukt_cell u_cell (
            .clk       (clk),
            .my_idx    (IDX_W'(i)),
            .ctrl      (ctrl),
            .nbr_key   (nbr_key),
            .nbr_value (nbr_value),
            .key       (cell_key[i]),
            .value     (cell_value[i]),
            .match     (cell_match[i])
        );
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_data_reg <= {OUT_CNT_W'(count_next),
                             (find_ok ? fv_reg : {VAL_W{1'b0}}),
                             ok};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// File: rtl/ukt_checker.sv
// Port-level checker of the unique key table, bound to the top level.
// Depends on ukt_pkg and unique_key_table_compacting_macros.svh.
`include "unique_key_table_compacting_macros.svh"

module ukt_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [ukt_pkg::OUT_W-1:0] m_axis_tdata
);
    import ukt_pkg::*;

    logic in_fire;
    logic out_hold;
    logic value_nz;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_hold = m_axis_tvalid && !m_axis_tready;
    assign value_nz = m_axis_tvalid && (m_axis_tdata[8:1] != 8'd0);

    // A result that is not taken keeps its contents.
    `UKT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_hold, m_axis_tvalid && $stable(m_axis_tdata))
    // After a transaction is taken in, the block is busy for its commit cycle.
    `UKT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !s_axis_tready)
    // The reported count never exceeds the table size.
    `UKT_ASSERT_NOW(a_count_range, clk, rst_n, m_axis_tvalid, m_axis_tdata[15:9] <= CAPACITY)
    // A nonzero value is only reported with success.
    `UKT_ASSERT_NOW(a_value_needs_ok, clk, rst_n, value_nz, m_axis_tdata[0])

endmodule

bind unique_key_table_compacting ukt_checker u_ukt_checker (.*);

// File: tb/unique_key_table_compacting_test.sv
// Self-checking testbench of the compacting unique key table: a queue-fed stream driver,
// a result monitor and an in-bench table model that predicts every response.
// Depends on ukt_pkg and the unique_key_table_compacting RTL only.
module unique_key_table_compacting_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ukt_pkg::*;

    localparam logic [1:0] OP_UNDEFINED = 2'd3;
    localparam int POOL_SIZE    = 96;
    localparam int RANDOM_ITEMS = 1200;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] key;
        logic [7:0]  value;
    } request_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] found_value;
        logic [6:0] entry_count;
    } response_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;

    request_t    request_q[$];
    response_t   expected_q[$];
    request_t    presented;
    int          mismatches = 0;
    int          issued = 0;

    // Model copy of the table contents.
    logic [31:0] table_keys[CAPACITY];
    logic [7:0]  table_vals[CAPACITY];
    int          table_fill = 0;

    logic [31:0] key_pool[POOL_SIZE];

    int tx_burst = 0;
    int tx_gap = 0;
    int rx_left = 0;
    int rx_mode = 0;

    unique_key_table_compacting uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Applies one request to the model table and returns the response it should give.
    function automatic response_t table_apply(request_t req);
        response_t resp;
        int hit;
        resp = '0;
        hit = -1;
        for (int i = 0; i < table_fill; i++)
        begin
            if (hit < 0 && table_keys[i] == req.key)
                hit = i;
        end
        case (req.op)
            OP_INSERT:
            begin
                if (hit < 0 && table_fill < CAPACITY)
                begin
                    table_keys[table_fill] = req.key;
                    table_vals[table_fill] = req.value;
                    table_fill++;
                    resp.ok = 1'b1;
                end
            end
            OP_FIND:
            begin
                if (hit >= 0)
                begin
                    resp.ok = 1'b1;
                    resp.found_value = table_vals[hit];
                end
            end
            OP_REMOVE:
            begin
                if (hit >= 0)
                begin
                    for (int j = hit; j + 1 < table_fill; j++)
                    begin
                        table_keys[j] = table_keys[j + 1];
                        table_vals[j] = table_vals[j + 1];
                    end
                    table_keys[table_fill - 1] = '0;
                    table_vals[table_fill - 1] = '0;
                    table_fill--;
                    resp.ok = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        resp.entry_count = 7'(table_fill);
        return resp;
    endfunction

    task automatic push_request(logic [1:0] op, logic [31:0] key, logic [7:0] value);
        request_t req;
        req.op = op;
        req.key = key;
        req.value = value;
        request_q.push_back(req);
        issued++;
    endtask

    // Holds off further requests until the table has answered everything sent so far.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (request_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0);
    endtask

    function automatic logic [1:0] pick_op(int mode);
        int roll;
        roll = $urandom_range(0, 99);
        case (mode)
            0: return (roll < 55) ? OP_INSERT : (roll < 80) ? OP_FIND
                                 : (roll < 95) ? OP_REMOVE : OP_UNDEFINED;
            1: return (roll < 35) ? OP_INSERT : (roll < 70) ? OP_FIND
                                 : (roll < 95) ? OP_REMOVE : OP_UNDEFINED;
            default: return (roll < 20) ? OP_INSERT : (roll < 50) ? OP_FIND
                                       : (roll < 95) ? OP_REMOVE : OP_UNDEFINED;
        endcase
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(table_apply(presented));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tx_burst == 0 && tx_gap == 0)
                begin
                    tx_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    tx_burst = $urandom_range(1, 24);
                end
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (request_q.size() > 0)
                begin
                    presented = request_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {6'b0, presented.value, presented.key, presented.op};
                    tx_burst--;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: alternates between always ready, coin-flip ready and mostly stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(10, 80);
            end
            rx_left--;
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Compares each accepted result transaction with the oldest prediction.
    always @(posedge clk)
    begin : monitor
        response_t got;
        response_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.ok = m_axis_tdata[0];
            got.found_value = m_axis_tdata[8:1];
            got.entry_count = m_axis_tdata[15:9];
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result ok=%0b value=%02h count=%0d",
                             $realtime, got.ok, got.found_value, got.entry_count);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.ok !== want.ok || got.found_value !== want.found_value
                    || got.entry_count !== want.entry_count)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: exp ok=%0b val=%02h cnt=%0d, got ok=%0b val=%02h cnt=%0d",
                                 $realtime, want.ok, want.found_value, want.entry_count,
                                 got.ok, got.found_value, got.entry_count);
                end
            end
        end
    end

    initial
    begin
        int span;
        int mode;
        int len;
        int start;
        int idx;
        logic [1:0] op;
        logic [31:0] key;

        for (int i = 0; i < CAPACITY; i++)
        begin
            table_keys[i] = '0;
            table_vals[i] = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table, the undefined request kind, key zero and all-ones key, duplicates,
        // removal from the middle and the oldest slot, and a cleared slot that must not match.
        push_request(OP_FIND,      32'h0000_0000, 8'h00);
        push_request(OP_REMOVE,    32'h0000_0000, 8'h00);
        push_request(OP_UNDEFINED, 32'h0000_0000, 8'h00);
        push_request(OP_INSERT,    32'h0000_0000, 8'h00);
        push_request(OP_INSERT,    32'hFFFF_FFFF, 8'hFF);
        push_request(OP_INSERT,    32'hA5A5_A5A5, 8'h5A);
        push_request(OP_INSERT,    32'h0000_0000, 8'h77);
        push_request(OP_FIND,      32'h0000_0000, 8'hFF);
        push_request(OP_FIND,      32'hFFFF_FFFF, 8'h00);
        push_request(OP_FIND,      32'h1234_5678, 8'h00);
        push_request(OP_REMOVE,    32'hFFFF_FFFF, 8'hFF);
        push_request(OP_FIND,      32'hA5A5_A5A5, 8'h00);
        push_request(OP_UNDEFINED, 32'hA5A5_A5A5, 8'hFF);
        push_request(OP_REMOVE,    32'hFFFF_FFFF, 8'h00);
        push_request(OP_REMOVE,    32'h0000_0000, 8'h00);
        push_request(OP_REMOVE,    32'hA5A5_A5A5, 8'h00);
        push_request(OP_FIND,      32'h0000_0000, 8'h00);
        push_request(OP_INSERT,    32'h5A5A_5A5A, 8'hAA);
        push_request(OP_UNDEFINED, 32'hFFFF_FFFF, 8'hFF);
        wait_drained();

        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            // Refresh part of the key pool so old entries and fresh keys mix.
            for (int i = 0; i < 16; i++)
                key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
            if ($urandom_range(0, 5) == 0)
            begin
                // Fill past capacity, hit duplicates, look keys up, then drain in rotated order.
                len = CAPACITY + 6;
                for (int i = 0; i < len; i++)
                    push_request(OP_INSERT, key_pool[i], 8'($urandom_range(0, 255)));
                for (int i = 0; i < 8; i++)
                    push_request(OP_INSERT, key_pool[$urandom_range(0, len - 1)],
                                 8'($urandom_range(0, 255)));
                for (int i = 0; i < 16; i++)
                    push_request(OP_FIND, key_pool[$urandom_range(0, len - 1)],
                                 8'($urandom_range(0, 255)));
                start = $urandom_range(0, len - 1);
                for (int i = 0; i < len; i++)
                    push_request(OP_REMOVE, key_pool[(start + i) % len],
                                 8'($urandom_range(0, 255)));
                wait_drained();
            end
            else
            begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(2, POOL_SIZE);
                len = $urandom_range(20, 80);
                for (int i = 0; i < len; i++)
                begin
                    op = pick_op(mode);
                    idx = $urandom_range(0, span - 1);
                    key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[idx];
                    push_request(op, key, 8'($urandom_range(0, 255)));
                end
            end
        end

        wait_drained();
        repeat (16) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #(4_000_000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/ukt_pkg.sv
rtl/ukt_cell.sv
rtl/unique_key_table_compacting.sv
rtl/ukt_checker.sv
tb/unique_key_table_compacting_test.sv
